/* hw/rtl/lpdk_pkg.sv */
package lpdk_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_MISS_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT_TYPE = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int IDLE_W   = 17;
  localparam int OFFSET_W = 12;
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
  localparam logic [7:0] MISS_MAX = '1;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_BYTE      = 3'd1,
    KIND_ECHO      = 3'd2,
    KIND_IDLE_DISC = 3'd3,
    KIND_LEN_ERR   = 3'd4
  } kind_t;

endpackage

/* hw/rtl/length_prefixed_deframer_keepalive.sv */
// Length-prefixed frame receiver with echo keepalive.
// Input channel (in_*): one item per handshake, either a received byte
// (in_tuser = 0, byte in in_tdata) or a one-second tick (in_tuser = 1).
// Output channel (out_*): exactly one result item per input item, in order.
// out_tuser carries the result kind, out_tlast marks the last byte of a frame.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; writing the
// idle interval also restarts the idle check countdown.
// An accepted item is registered in the input register; its result is then
// registered in the output register when the input register advances.
// Throughput: one item per cycle; the input register and the result register
// each advance every cycle the output is free or being taken.
// When out_tready is low the result is held and one more item is taken into
// the input register; after that in_tready drops until the output drains.
// Reset (rst_n low at a clock edge) empties both registers, reopens the link,
// clears frame and keepalive state and loads the register defaults.
// Once the link is closed every item gives kind none with link_closed set.
module length_prefixed_deframer_keepalive
  import lpdk_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic [0:0]            in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [7:0] frame_byte, [19:8] byte_offset,
                                            // [20] disconnect_request, [21] link_closed
  output logic [2:0]            out_tuser,  // [2:0] kind
  output logic                  out_tlast,  // end_of_frame
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FC_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

  logic        s0_valid_r;
  logic        s0_op_r;
  logic [7:0]  s0_byte_r;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_byte_r;
  logic [OFFSET_W-1:0] out_off_r;
  logic        out_eof_r, out_disc_r, out_closed_r;

  logic [15:0] idle_interval_r;
  logic [7:0]  echo_miss_limit_r;
  logic [7:0]  disconnect_type_r;

  logic [FC_W-1:0]   frame_count_r, frame_count_nxt;
  logic [15:0]       decl_len_r, decl_len_nxt;
  logic [7:0]        frame_type_r, frame_type_nxt;
  logic [IDLE_W-1:0] idle_sec_r, idle_sec_nxt;
  logic [15:0]       countdown_r, countdown_nxt;
  logic [7:0]        missed_r, missed_nxt;
  logic              running_r, running_nxt;

  kind_t       kind_nxt;
  logic [7:0]  byte_nxt;
  logic [OFFSET_W-1:0] off_nxt;
  logic        eof_nxt, disc_nxt;

  logic        s1_free, advance, in_acc;
  logic [16:0] count_inc;
  logic        len_bad;

  assign s1_free   = !out_valid_r || out_tready;
  assign advance   = s0_valid_r && s1_free;
  assign in_tready = !s0_valid_r || s1_free;
  assign in_acc    = in_tvalid && in_tready;
  assign count_inc = 17'(frame_count_r) + 17'd1;

  always_comb begin
    frame_count_nxt = frame_count_r;
    decl_len_nxt    = decl_len_r;
    frame_type_nxt  = frame_type_r;
    idle_sec_nxt    = idle_sec_r;
    countdown_nxt   = countdown_r;
    missed_nxt      = missed_r;
    running_nxt     = running_r;
    kind_nxt        = KIND_NONE;
    byte_nxt        = '0;
    off_nxt         = '0;
    eof_nxt         = 1'b0;
    disc_nxt        = 1'b0;
    len_bad         = 1'b0;
    if (running_r) begin
      if (s0_op_r == OP_BYTE) begin
        if (frame_count_r == FC_W'(0)) begin
          decl_len_nxt = {s0_byte_r, 8'h00};
        end else if (frame_count_r == FC_W'(1)) begin
          decl_len_nxt = {decl_len_r[15:8], s0_byte_r};
        end else if (frame_count_r == FC_W'(2)) begin
          frame_type_nxt = s0_byte_r;
        end
        frame_count_nxt = FC_W'(count_inc);
        byte_nxt        = s0_byte_r;
        off_nxt         = OFFSET_W'(frame_count_r);
        len_bad = (frame_count_r == FC_W'(1)) &&
                  (({1'b0, decl_len_nxt} < 17'd3) || ({1'b0, decl_len_nxt} > MAX_LEN));
        if (len_bad) begin
          frame_count_nxt = '0;
          kind_nxt        = KIND_LEN_ERR;
        end else begin
          kind_nxt = KIND_BYTE;
          if (count_inc > 17'd2 && count_inc == {1'b0, decl_len_nxt}) begin
            eof_nxt         = 1'b1;
            frame_count_nxt = '0;
            missed_nxt      = '0;
            idle_sec_nxt    = '0;
            if (frame_type_nxt == disconnect_type_r) begin
              disc_nxt    = 1'b1;
              running_nxt = 1'b0;
            end
          end
        end
      end else begin
        if (idle_sec_r != IDLE_MAX) begin
          idle_sec_nxt = idle_sec_r + IDLE_W'(1);
        end
        if (idle_interval_r != 16'd0) begin
          if (countdown_r > 16'd1) begin
            countdown_nxt = countdown_r - 16'd1;
          end else begin
            countdown_nxt = idle_interval_r;
            if (idle_sec_nxt > IDLE_W'(idle_interval_r)) begin
              if (missed_r >= echo_miss_limit_r) begin
                kind_nxt        = KIND_IDLE_DISC;
                running_nxt     = 1'b0;
                frame_count_nxt = '0;
              end else begin
                kind_nxt = KIND_ECHO;
                if (missed_r != MISS_MAX) begin
                  missed_nxt = missed_r + 8'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      idle_interval_r   <= 16'd0;
      echo_miss_limit_r <= 8'd3;
      disconnect_type_r <= 8'd0;
      frame_count_r     <= '0;
      decl_len_r        <= '0;
      frame_type_r      <= '0;
      idle_sec_r        <= '0;
      countdown_r       <= 16'd0;
      missed_r          <= '0;
      running_r         <= 1'b1;
    end else begin
      if (in_acc) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        frame_count_r <= frame_count_nxt;
        decl_len_r    <= decl_len_nxt;
        frame_type_r  <= frame_type_nxt;
        idle_sec_r    <= idle_sec_nxt;
        countdown_r   <= countdown_nxt;
        missed_r      <= missed_nxt;
        running_r     <= running_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IDLE_INTERVAL: begin
            idle_interval_r <= cfg_wdata;
            countdown_r     <= cfg_wdata;
          end
          REG_ECHO_MISS_LIMIT: echo_miss_limit_r <= cfg_wdata[7:0];
          REG_DISCONNECT_TYPE: disconnect_type_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_op_r   <= in_tuser[0];
      s0_byte_r <= in_tdata;
    end
    if (advance) begin
      out_kind_r   <= kind_nxt;
      out_byte_r   <= byte_nxt;
      out_off_r    <= off_nxt;
      out_eof_r    <= eof_nxt;
      out_disc_r   <= disc_nxt;
      out_closed_r <= !running_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_eof_r;
  assign out_tdata  = {2'b00, out_closed_r, out_disc_r, out_off_r, out_byte_r};

endmodule

/* hw/rtl/lpdk_checker.sv */
module lpdk_checker
  import lpdk_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  logic closed_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tdata[21]) begin
      closed_seen_r <= 1'b1;
    end
  end

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_eof_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_BYTE)
    else $error("end of frame on a non-byte item");

  a_disc_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> out_tlast && out_tdata[21])
    else $error("disconnect request without frame end and close");

  // closed link stays closed and goes quiet
  a_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && closed_seen_r |-> out_tdata[21] && out_tuser == KIND_NONE)
    else $error("activity after link closed");

endmodule

bind length_prefixed_deframer_keepalive lpdk_checker u_lpdk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
